### src/amad_pkg.sv
// Package for the AArch64 load/store address decoder.
// Field widths, instruction class codes and extend option codes.
// No dependencies; used by the interfaces and the top level.
package amad_pkg;

   localparam int unsigned RegIdxW = 5;
   localparam int unsigned DataW   = 64;
   localparam int unsigned InstrW  = 32;
   localparam int unsigned BytesW  = 5;
   localparam int unsigned NumRegs = 32;

   // func codes on the request channel
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_DECODE = 1'b1;

   // instruction class, bits 29:28
   localparam logic [1:0] CLS_EXCL   = 2'b00;
   localparam logic [1:0] CLS_PAIR   = 2'b10;
   localparam logic [1:0] CLS_SINGLE = 2'b11;

   // single register index modes, bits 11:10
   localparam logic [1:0] MODE_POST   = 2'b01;
   localparam logic [1:0] MODE_REGOFF = 2'b10;

   // pair index modes, bits 24:23
   localparam logic [1:0] PMODE_NOALLOC = 2'b00;
   localparam logic [1:0] PMODE_POST    = 2'b01;

   // register offset extend options, bits 15:13
   localparam logic [2:0] OPT_UXTW = 3'b010;
   localparam logic [2:0] OPT_SXTW = 3'b110;

   // register 31: SP as base, zero as offset
   localparam logic [RegIdxW-1:0] SP_INDEX = 5'd31;

   typedef logic [DataW-1:0] data_type;
   typedef logic [InstrW-1:0] instr_type;

endpackage

### src/amad_if.sv
// Valid/ready channel interfaces for the request and response sides.
// Depends on amad_pkg for payload widths.
interface amad_req_if;
   logic                             valid;
   logic                             ready;
   logic                             func;
   logic [amad_pkg::RegIdxW-1:0]     reg_index;
   amad_pkg::data_type               reg_value;
   amad_pkg::instr_type              instruction;

   modport source (output valid, func, reg_index, reg_value, instruction, input ready);
   modport sink   (input valid, func, reg_index, reg_value, instruction, output ready);
endinterface

interface amad_rsp_if;
   logic                             valid;
   logic                             ready;
   logic                             access_valid;
   logic                             is_store;
   logic                             is_paired;
   logic [amad_pkg::BytesW-1:0]      access_bytes;
   amad_pkg::data_type               effective_address;
   amad_pkg::data_type               second_address;

   modport source (output valid, access_valid, is_store, is_paired, access_bytes,
                   effective_address, second_address, input ready);
   modport sink   (input valid, access_valid, is_store, is_paired, access_bytes,
                   effective_address, second_address, output ready);
endinterface

### src/aarch64_mem_access_decode.sv
// AArch64 load/store address decoder with a 32 x 64 register file.
// Depends on amad_pkg and the channel interfaces in amad_if.sv.
//
//   channel   direction  transaction
//   req_if    in         write register entry (func 0) or decode instruction (func 1)
//   rsp_if    out        one decode result per decode transaction, none for writes
//
// One transaction per cycle while req_if.ready is high. A decode reaches the response
// register through the decode stage: the register file is read on accept, address math runs in the next cycle.
// A write is committed at its accept edge, so a decode right behind it sees it.
// Reset clears the entry valid bits; an unwritten entry reads as zero.
// A stalled response holds the decode stage; req_if.ready drops only when both are full.
module aarch64_mem_access_decode (
   input  logic           clock,
   input  logic           reset,
   amad_req_if.sink       req_if,
   amad_rsp_if.source     rsp_if
);

   // register file and per-entry valid bits
   amad_pkg::data_type                  rf_mem [amad_pkg::NumRegs];
   logic [amad_pkg::NumRegs-1:0]        rf_vld_ff, rf_vld_in;

   // decode stage
   logic                                s0_valid_ff, s0_valid_in;
   amad_pkg::instr_type                 s0_instr_ff;
   amad_pkg::data_type                  base_rd_ff, off_rd_ff;
   logic                                base_vld_ff, off_vld_ff;

   // response register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                acc_valid_ff, acc_valid_in;
   logic                                store_ff, store_in;
   logic                                paired_ff, paired_in;
   logic [amad_pkg::BytesW-1:0]         bytes_ff, bytes_in;
   amad_pkg::data_type                  ea_ff, ea_in;
   amad_pkg::data_type                  sa_ff, sa_in;

   logic                                accept, take_dec, take_wr, s1_free, s0_adv;
   logic [amad_pkg::RegIdxW-1:0]        base_idx, off_idx;

   assign s1_free  = !rsp_valid_ff || rsp_if.ready;
   assign s0_adv   = s0_valid_ff && s1_free;
   assign req_if.ready = !s0_valid_ff || s1_free;
   assign accept   = req_if.valid && req_if.ready;
   assign take_dec = accept && (req_if.func == amad_pkg::FUNC_DECODE);
   assign take_wr  = accept && (req_if.func == amad_pkg::FUNC_WRITE);
   assign base_idx = req_if.instruction[9:5];
   assign off_idx  = req_if.instruction[20:16];

   always_comb begin
      rf_vld_in = rf_vld_ff;
      if (take_wr) begin
         rf_vld_in[req_if.reg_index] = 1'b1;
      end
   end

   always_comb begin
      s0_valid_in = s0_valid_ff;
      if (take_dec) begin
         s0_valid_in = 1'b1;
      end else if (s0_adv) begin
         s0_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (s0_adv) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // register file: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (take_wr) begin
         rf_mem[req_if.reg_index] <= req_if.reg_value;
      end
      if (take_dec) begin
         base_rd_ff  <= rf_mem[base_idx];
         off_rd_ff   <= rf_mem[off_idx];
         base_vld_ff <= rf_vld_ff[base_idx];
         off_vld_ff  <= rf_vld_ff[off_idx] && (off_idx != amad_pkg::SP_INDEX);
         s0_instr_ff <= req_if.instruction;
      end
   end

   // decode and address calculation
   logic [1:0]          sz, opc, cls, mode, pmode;
   logic                v;
   logic [2:0]          scale;
   logic                valid_c, store_c, paired_c, add_en;
   amad_pkg::data_type  base, roff, addend, sum;
   logic [amad_pkg::BytesW-1:0] bytes_c;

   always_comb begin
      sz      = s0_instr_ff[31:30];
      v       = s0_instr_ff[26];
      opc     = s0_instr_ff[23:22];
      cls     = s0_instr_ff[29:28];
      mode    = s0_instr_ff[11:10];
      pmode   = s0_instr_ff[24:23];
      base    = base_vld_ff ? base_rd_ff : '0;
      roff    = off_vld_ff ? off_rd_ff : '0;
      scale   = {1'b0, sz};
      valid_c = 1'b0;
      store_c = 1'b0;
      paired_c = 1'b0;
      add_en  = 1'b0;
      addend  = '0;

      case (s0_instr_ff[15:13])
         amad_pkg::OPT_UXTW: roff = {32'b0, roff[31:0]};
         amad_pkg::OPT_SXTW: roff = {{32{roff[31]}}, roff[31:0]};
         default:            roff = roff;
      endcase

      if (s0_instr_ff[27] && !s0_instr_ff[25]) begin
         case (cls)
            amad_pkg::CLS_SINGLE: begin
               valid_c = 1'b1;
               if (v) begin
                  // Q form: size field 00 with opc 1x is a 16-byte access
                  scale   = (sz == 2'b00 && opc[1]) ? 3'd4 : {1'b0, sz};
                  store_c = !opc[0];
               end else begin
                  store_c = (opc == 2'b00);
               end
               if (s0_instr_ff[24]) begin
                  add_en = 1'b1;
                  addend = {52'b0, s0_instr_ff[21:10]} << scale;
               end else if (mode == amad_pkg::MODE_POST) begin
                  add_en = 1'b0;
               end else if (mode == amad_pkg::MODE_REGOFF) begin
                  add_en = 1'b1;
                  addend = s0_instr_ff[12] ? (roff << scale) : roff;
               end else begin
                  add_en = 1'b1;
                  addend = {{55{s0_instr_ff[20]}}, s0_instr_ff[20:12]};
               end
            end
            amad_pkg::CLS_PAIR: begin
               scale = v ? (3'd2 + {1'b0, sz}) : (sz[1] ? 3'd3 : 3'd2);
               if (pmode != amad_pkg::PMODE_NOALLOC && !(v && sz == 2'b11)) begin
                  valid_c  = 1'b1;
                  paired_c = 1'b1;
                  store_c  = !s0_instr_ff[22];
                  add_en   = (pmode != amad_pkg::PMODE_POST);
                  addend   = {{57{s0_instr_ff[21]}}, s0_instr_ff[21:15]} << scale;
               end
            end
            amad_pkg::CLS_EXCL: begin
               if (!v && !s0_instr_ff[23]) begin
                  valid_c  = 1'b1;
                  paired_c = s0_instr_ff[21];
                  store_c  = !s0_instr_ff[22];
               end
            end
            default: valid_c = 1'b0;
         endcase
      end

      bytes_c = 5'd1 << scale;
      sum     = add_en ? (base + addend) : base;

      acc_valid_in = valid_c;
      store_in     = valid_c && store_c;
      paired_in    = valid_c && paired_c;
      bytes_in     = valid_c ? bytes_c : '0;
      ea_in        = valid_c ? sum : '0;
      sa_in        = (valid_c && paired_c) ? (sum + {59'b0, bytes_c}) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rf_vld_ff    <= '0;
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rf_vld_ff    <= rf_vld_in;
         s0_valid_ff  <= s0_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_adv) begin
         acc_valid_ff <= acc_valid_in;
         store_ff     <= store_in;
         paired_ff    <= paired_in;
         bytes_ff     <= bytes_in;
         ea_ff        <= ea_in;
         sa_ff        <= sa_in;
      end
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.access_valid      = acc_valid_ff;
   assign rsp_if.is_store          = store_ff;
   assign rsp_if.is_paired         = paired_ff;
   assign rsp_if.access_bytes      = bytes_ff;
   assign rsp_if.effective_address = ea_ff;
   assign rsp_if.second_address    = sa_ff;

endmodule
